### sv/i2cm_pkg.sv
// Shared types, codes and constants for the I2C master byte engine.
`default_nettype none
package i2cm_pkg;

  localparam int unsigned FIFO_DEPTH     = 4;
  localparam logic [15:0] HALF_RESET     = 16'd100;
  localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;

  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_START      = 3'd1,
    MODE_STOP       = 3'd2,
    MODE_WRITE      = 3'd3,
    MODE_READ_ACK   = 3'd4,
    MODE_READ_NACK  = 3'd5
  } mode_code_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ_ACK,
    CMD_READ_NACK
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST_DH = 4'd1,
    PH_ST_CH = 4'd2,
    PH_ST_DL = 4'd3,
    PH_ST_CL = 4'd4,
    PH_SP_DL = 4'd5,
    PH_SP_CH = 4'd6,
    PH_SP_DH = 4'd7,
    PH_W_SDA = 4'd8,
    PH_W_CH  = 4'd9,
    PH_W_CL  = 4'd10,
    PH_R_SDA = 4'd11,
    PH_R_CH  = 4'd12,
    PH_R_CL  = 4'd13,
    PH_R_REL = 4'd14
  } phase_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] read_byte;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_data;
    logic       sda_in;
  } cls_item_t;

endpackage
`default_nettype wire

### sv/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: front queue, engine and result queue.
// Each item is one bus tick and gives exactly one result. The block takes one item per
// clock cycle and gives one result per cycle while the front queue holds an item and the
// result queue has room: the engine registers its phase, tick counter and line levels on
// each accepted item. An item is registered in the front queue and its result in the
// result queue before the result can be popped. Both queues hold QueueDepth items; full
// rises when the front queue is full, and the engine pauses while the result queue is
// full. The half period register is written through the cfg channel, which is always
// ready; write it only while no items are in flight.
`default_nettype none
module i2c_master_byte_engine #(
  parameter int unsigned QueueDepth = i2cm_pkg::FIFO_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire i2cm_pkg::in_item_t  cmd_item,
  output logic                     empty,
  input  wire logic                pop,
  output i2cm_pkg::out_item_t      res_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [15:0]         cfg_data
);
  import i2cm_pkg::*;

  cls_item_t                    cls_item;
  logic                         q_empty;
  logic                         res_full;
  logic                         step;
  out_item_t                    eng_res;
  logic [$bits(out_item_t)-1:0] res_rdata;

  assign step = !q_empty && !res_full;

  i2cm_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .cmd_item (cmd_item),
    .full     (full),
    .pop      (step),
    .cls_item (cls_item),
    .empty    (q_empty)
  );

  i2cm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .step      (step),
    .cls_item  (cls_item),
    .res_item  (eng_res)
  );

  i2cm_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (QueueDepth)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (step),
    .wdata (eng_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_item = out_item_t'(res_rdata);
endmodule
`default_nettype wire

### sv/i2cm_fifo.sv
// Small register queue with push/full and pop/empty sides.
`default_nettype none
module i2cm_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [Width-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [Width-1:0]      rdata,
  output logic                  empty
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/i2cm_front.sv
// Front end: decodes the mode of each item and queues it for the engine.
`default_nettype none
module i2cm_front #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire i2cm_pkg::in_item_t   cmd_item,
  output logic                      full,
  input  wire logic                 pop,
  output i2cm_pkg::cls_item_t       cls_item,
  output logic                      empty
);
  import i2cm_pkg::*;

  cls_item_t                 cls_in;
  logic [$bits(cls_item_t)-1:0] q_rdata;

  always_comb begin
    cls_in.write_data = cmd_item.write_data;
    cls_in.sda_in     = cmd_item.sda_in;
    unique case (cmd_item.mode)
      MODE_START:     cls_in.cmd = CMD_START;
      MODE_STOP:      cls_in.cmd = CMD_STOP;
      MODE_WRITE:     cls_in.cmd = CMD_WRITE;
      MODE_READ_ACK:  cls_in.cmd = CMD_READ_ACK;
      MODE_READ_NACK: cls_in.cmd = CMD_READ_NACK;
      default:        cls_in.cmd = CMD_NONE;
    endcase
  end

  i2cm_fifo #(
    .Width ($bits(cls_item_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls_in),
    .full  (full),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (empty)
  );

  assign cls_item = cls_item_t'(q_rdata);
endmodule
`default_nettype wire

### sv/i2cm_engine.sv
// Back end: bus phase sequencer, bit timing and the half period register.
`default_nettype none
module i2cm_engine (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 step,
  input  wire i2cm_pkg::cls_item_t  cls_item,
  output i2cm_pkg::out_item_t       res_item
);
  import i2cm_pkg::*;

  logic [15:0] half_period;
  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic        ack_flag, ack_flag_next;
  logic        give_ack, give_ack_next;
  logic [7:0]  read_reg, read_reg_next;
  logic        done, rej, enter_en;
  phase_t      enter_ph;
  logic [15:0] reload;
  logic        bc_low;

  assign cfg_ready = 1'b1;
  assign reload    = (half_period == '0) ? 16'd1 : half_period;
  assign bc_low    = (bit_count < BITS_PER_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_RESET;
    end else if (cfg_valid) begin
      half_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      tick_count <= '0;
      shift_byte <= '0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      ack_flag   <= 1'b0;
      give_ack   <= 1'b0;
      read_reg   <= '0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      tick_count <= tick_count_next;
      shift_byte <= shift_byte_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      ack_flag   <= ack_flag_next;
      give_ack   <= give_ack_next;
      read_reg   <= read_reg_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    tick_count_next = tick_count;
    shift_byte_next = shift_byte;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    ack_flag_next   = ack_flag;
    give_ack_next   = give_ack;
    read_reg_next   = read_reg;
    done            = 1'b0;
    rej             = 1'b0;
    enter_en        = 1'b0;
    enter_ph        = PH_IDLE;

    if (phase == PH_IDLE) begin
      unique case (cls_item.cmd)
        CMD_START: begin
          enter_en = 1'b1;
          enter_ph = PH_ST_DH;
        end
        CMD_STOP: begin
          enter_en = 1'b1;
          enter_ph = PH_SP_DL;
        end
        CMD_WRITE: begin
          shift_byte_next = cls_item.write_data;
          bit_count_next  = '0;
          enter_en        = 1'b1;
          enter_ph        = PH_W_SDA;
        end
        CMD_READ_ACK, CMD_READ_NACK: begin
          give_ack_next   = (cls_item.cmd == CMD_READ_ACK);
          shift_byte_next = '0;
          bit_count_next  = '0;
          enter_en        = 1'b1;
          enter_ph        = PH_R_SDA;
        end
        default: ;
      endcase
    end else begin
      rej = (cls_item.cmd != CMD_NONE);
      if (tick_count > 16'd1) begin
        tick_count_next = tick_count - 16'd1;
      end else begin
        tick_count_next = '0;
        unique case (phase)
          PH_ST_DH: begin enter_en = 1'b1; enter_ph = PH_ST_CH; end
          PH_ST_CH: begin enter_en = 1'b1; enter_ph = PH_ST_DL; end
          PH_ST_DL: begin enter_en = 1'b1; enter_ph = PH_ST_CL; end
          PH_SP_DL: begin enter_en = 1'b1; enter_ph = PH_SP_CH; end
          PH_SP_CH: begin enter_en = 1'b1; enter_ph = PH_SP_DH; end
          PH_W_SDA: begin enter_en = 1'b1; enter_ph = PH_W_CH; end
          PH_R_SDA: begin enter_en = 1'b1; enter_ph = PH_R_CH; end
          PH_W_CH: begin
            if (!bc_low) begin
              ack_flag_next = ~cls_item.sda_in;
            end
            enter_en = 1'b1;
            enter_ph = PH_W_CL;
          end
          PH_W_CL: begin
            if (bc_low) begin
              bit_count_next = bit_count + 4'd1;
              enter_en       = 1'b1;
              enter_ph       = PH_W_SDA;
            end else begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end
          end
          PH_R_CH: begin
            if (bc_low) begin
              shift_byte_next = {shift_byte[6:0], cls_item.sda_in};
            end
            enter_en = 1'b1;
            enter_ph = PH_R_CL;
          end
          PH_R_CL: begin
            if (bc_low) begin
              bit_count_next = bit_count + 4'd1;
              enter_en       = 1'b1;
              enter_ph       = PH_R_SDA;
            end else if (give_ack) begin
              enter_en = 1'b1;
              enter_ph = PH_R_REL;
            end else begin
              read_reg_next = shift_byte;
              phase_next    = PH_IDLE;
              done          = 1'b1;
            end
          end
          PH_R_REL: begin
            read_reg_next = shift_byte;
            phase_next    = PH_IDLE;
            done          = 1'b1;
          end
          PH_ST_CL, PH_SP_DH: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end

    if (enter_en) begin
      phase_next      = enter_ph;
      tick_count_next = reload;
      unique case (enter_ph)
        PH_ST_DH, PH_SP_DH, PH_R_REL:  sda_reg_next = 1'b1;
        PH_ST_DL, PH_SP_DL:            sda_reg_next = 1'b0;
        PH_ST_CH, PH_SP_CH, PH_W_CH,
        PH_R_CH:                       scl_reg_next = 1'b1;
        PH_ST_CL, PH_W_CL, PH_R_CL:    scl_reg_next = 1'b0;
        PH_W_SDA: begin
          sda_reg_next = (bit_count_next < BITS_PER_BYTE) ?
                         shift_byte_next[3'd7 - bit_count_next[2:0]] : 1'b1;
        end
        PH_R_SDA: begin
          sda_reg_next = (bit_count_next < BITS_PER_BYTE) ? 1'b1 : ~give_ack_next;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_item.scl_level = scl_reg_next;
    res_item.sda_level = sda_reg_next;
    res_item.busy_res  = (phase_next != PH_IDLE);
    res_item.done_res  = done;
    res_item.ack_seen  = ack_flag_next;
    res_item.read_byte = read_reg_next;
    res_item.rejected  = rej;
  end

  a_busy_has_ticks: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (tick_count != '0))
    else $error("active phase with an empty tick counter");

  a_idle_no_ticks: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_count == '0))
    else $error("idle with ticks pending");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BITS_PER_BYTE)
    else $error("bit counter past a byte");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (step && done) |=> (phase == PH_IDLE))
    else $error("done without returning to idle");
endmodule
`default_nettype wire

### verif/i2c_master_byte_engine_test.sv
// Self-checking testbench for the I2C master byte engine: directed table, then random items.
`timescale 1ns / 100ps
module i2c_master_byte_engine_test;
  import i2cm_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam out_item_t AT_REST      = {1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam out_item_t START_HELD   = {1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam out_item_t START_BLOCKS = {1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1};

  typedef struct packed {
    logic        set_half;
    logic [15:0] half;
    in_item_t    item;
    logic        run_out;
    logic        typed;
    out_item_t   want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  in_item_t    cmd_item;
  logic        empty;
  logic        pop;
  out_item_t   res_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // bus engine state as seen by the checker
  logic [15:0] half_q    = HALF_RESET;
  phase_t      phase_q   = PH_IDLE;
  logic [3:0]  bit_idx   = 4'd0;
  logic [15:0] hold_left = 16'd0;
  logic [7:0]  byte_sr   = 8'h00;
  logic        scl_q     = 1'b1;
  logic        sda_q     = 1'b1;
  logic        ack_q     = 1'b0;
  logic        ack_drive = 1'b0;
  logic [7:0]  byte_rx   = 8'h00;

  out_item_t   status_due[$];
  step_row_t   plan [0:31];
  int          plan_len      = 0;
  int          mismatches    = 0;
  int          status_popped = 0;
  int          send_gap_pct  = 21;
  int          recv_gap_pct  = 76;
  bit          held_off      = 1'b0;

  i2c_master_byte_engine dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd_item  (cmd_item),
    .empty     (empty),
    .pop       (pop),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void set_phase(input phase_t p);
    phase_q   = p;
    hold_left = (half_q == 16'd0) ? 16'd1 : half_q;
    case (p)
      PH_ST_DH, PH_SP_DH, PH_R_REL: sda_q = 1'b1;
      PH_ST_DL, PH_SP_DL: sda_q = 1'b0;
      PH_ST_CH, PH_SP_CH, PH_W_CH, PH_R_CH: scl_q = 1'b1;
      PH_ST_CL, PH_W_CL, PH_R_CL: scl_q = 1'b0;
      PH_W_SDA: begin
        sda_q = (bit_idx < BITS_PER_BYTE) ? byte_sr[3'd7 - bit_idx[2:0]] : 1'b1;
      end
      PH_R_SDA: begin
        sda_q = (bit_idx < BITS_PER_BYTE) ? 1'b1 : !ack_drive;
      end
      default: begin
        phase_q   = PH_IDLE;
        hold_left = 16'd0;
      end
    endcase
  endfunction

  // last tick of a hold: move to the next level, 1 when the command is over
  function automatic logic end_of_hold(input logic sda);
    logic finished;
    finished = 1'b0;
    case (phase_q)
      PH_ST_DH: set_phase(PH_ST_CH);
      PH_ST_CH: set_phase(PH_ST_DL);
      PH_ST_DL: set_phase(PH_ST_CL);
      PH_SP_DL: set_phase(PH_SP_CH);
      PH_SP_CH: set_phase(PH_SP_DH);
      PH_W_SDA: set_phase(PH_W_CH);
      PH_R_SDA: set_phase(PH_R_CH);
      PH_W_CH: begin
        if (bit_idx >= BITS_PER_BYTE) ack_q = !sda;
        set_phase(PH_W_CL);
      end
      PH_W_CL: begin
        if (bit_idx < BITS_PER_BYTE) begin
          bit_idx = bit_idx + 4'd1;
          set_phase(PH_W_SDA);
        end else begin
          finished = 1'b1;
        end
      end
      PH_R_CH: begin
        if (bit_idx < BITS_PER_BYTE) byte_sr = {byte_sr[6:0], sda};
        set_phase(PH_R_CL);
      end
      PH_R_CL: begin
        if (bit_idx < BITS_PER_BYTE) begin
          bit_idx = bit_idx + 4'd1;
          set_phase(PH_R_SDA);
        end else if (ack_drive) begin
          set_phase(PH_R_REL);
        end else begin
          byte_rx  = byte_sr;
          finished = 1'b1;
        end
      end
      PH_R_REL: begin
        byte_rx  = byte_sr;
        finished = 1'b1;
      end
      PH_ST_CL, PH_SP_DH: finished = 1'b1;
      default: ;
    endcase
    if (finished || phase_q == PH_IDLE) begin
      phase_q   = PH_IDLE;
      hold_left = 16'd0;
    end
    return finished;
  endfunction

  function automatic out_item_t engine_tick(input in_item_t it);
    out_item_t st;
    logic      done;
    logic      rej;
    done = 1'b0;
    rej  = 1'b0;
    if (phase_q == PH_IDLE) begin
      case (it.mode)
        MODE_START: set_phase(PH_ST_DH);
        MODE_STOP:  set_phase(PH_SP_DL);
        MODE_WRITE: begin
          byte_sr = it.write_data;
          bit_idx = 4'd0;
          set_phase(PH_W_SDA);
        end
        MODE_READ_ACK, MODE_READ_NACK: begin
          ack_drive = (it.mode == MODE_READ_ACK);
          byte_sr   = 8'h00;
          bit_idx   = 4'd0;
          set_phase(PH_R_SDA);
        end
        default: ;
      endcase
    end else begin
      rej = (it.mode >= MODE_START) && (it.mode <= MODE_READ_NACK);
      if (hold_left > 16'd1) begin
        hold_left = hold_left - 16'd1;
      end else begin
        hold_left = 16'd0;
        done      = end_of_hold(it.sda_in);
      end
    end
    st.scl_level = scl_q;
    st.sda_level = sda_q;
    st.busy_res  = (phase_q != PH_IDLE);
    st.done_res  = done;
    st.ack_seen  = ack_q;
    st.read_byte = byte_rx;
    st.rejected  = rej;
    return st;
  endfunction

  function automatic void add_row(input logic set_half, input logic [15:0] half,
                                  input logic [2:0] mode, input logic [7:0] data,
                                  input logic sda, input logic run_out,
                                  input logic typed, input out_item_t want);
    plan[plan_len] = {set_half, half, mode, data, sda, run_out, typed, want};
    plan_len++;
  endfunction

  task automatic check_field(input string nm, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, nm, want, got);
      mismatches++;
    end
  endtask

  task automatic check_status(input out_item_t got);
    out_item_t want;
    if (status_due.size() == 0) begin
      $display("%0t: unexpected item, expected none got %h", $time, got);
      mismatches++;
    end else begin
      want = status_due.pop_front();
      check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      check_field("done_res", 8'(want.done_res), 8'(got.done_res));
      check_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
      check_field("read_byte", want.read_byte, got.read_byte);
      check_field("rejected", 8'(want.rejected), 8'(got.rejected));
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance with push still high
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push     <= 1'b1;
    cmd_item <= it;
    do @(posedge clk); while (full);
    predicted = engine_tick(it);
    status_due.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic run_out(input logic sda);
    in_item_t it;
    while (phase_q != PH_IDLE) begin
      it.mode       = MODE_TICK;
      it.write_data = 8'($urandom_range(255));
      it.sda_in     = sda;
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic write_half(input logic [15:0] v);
    push <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    half_q = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_run(input int count);
    in_item_t it;
    repeat (count) begin
      it.write_data = 8'($urandom_range(255));
      it.sda_in     = 1'($urandom_range(1));
      if (phase_q != PH_IDLE) begin
        if ($urandom_range(99) < 8) it.mode = 3'($urandom_range(7));
        else it.mode = MODE_TICK;
      end else begin
        if ($urandom_range(99) < 85) it.mode = 3'($urandom_range(MODE_START, MODE_READ_NACK));
        else it.mode = 3'($urandom_range(7));
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      check_status(res_item);
      status_popped++;
    end
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && status_popped >= 60) begin
        // long stall so the front queue fills and full rises
        held_off = 1'b1;
        pop <= 1'b0;
        repeat (60) @(negedge clk);
      end else if (!rst) begin
        pop <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  initial begin
    #5000000;
    $display("i2c_master_byte_engine_test failed");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    cmd_item  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;

    // reset half period, idle modes, then commands against a busy engine
    add_row(1'b0, 16'd0, MODE_TICK,      8'h00, 1'b0, 1'b0, 1'b1, AT_REST);
    add_row(1'b0, 16'd0, MODE_SPARE_LO,  8'hFF, 1'b1, 1'b0, 1'b1, AT_REST);
    add_row(1'b0, 16'd0, MODE_SPARE_HI,  8'h00, 1'b1, 1'b0, 1'b1, AT_REST);
    add_row(1'b0, 16'd0, MODE_START,     8'h00, 1'b0, 1'b0, 1'b1, START_HELD);
    add_row(1'b0, 16'd0, MODE_STOP,      8'h00, 1'b0, 1'b0, 1'b1, START_BLOCKS);
    add_row(1'b0, 16'd0, MODE_WRITE,     8'hFF, 1'b0, 1'b0, 1'b1, START_BLOCKS);
    add_row(1'b0, 16'd0, MODE_READ_ACK,  8'h00, 1'b0, 1'b0, 1'b1, START_BLOCKS);
    add_row(1'b0, 16'd0, MODE_READ_NACK, 8'h00, 1'b1, 1'b1, 1'b1, START_BLOCKS);
    // zero half period behaves as one
    add_row(1'b1, 16'd0, MODE_WRITE,     8'hA5, 1'b0, 1'b1, 1'b0, '0);
    add_row(1'b0, 16'd0, MODE_WRITE,     8'hFF, 1'b1, 1'b1, 1'b0, '0);
    add_row(1'b0, 16'd0, MODE_WRITE,     8'h00, 1'b0, 1'b1, 1'b0, '0);
    add_row(1'b0, 16'd0, MODE_READ_ACK,  8'h00, 1'b1, 1'b1, 1'b0, '0);
    add_row(1'b0, 16'd0, MODE_READ_NACK, 8'hFF, 1'b0, 1'b1, 1'b0, '0);
    // stop lands on the tick the start finishes
    add_row(1'b0, 16'd0, MODE_START,     8'h00, 1'b1, 1'b0, 1'b0, '0);
    add_row(1'b0, 16'd0, MODE_TICK,      8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b0, 16'd0, MODE_TICK,      8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b0, 16'd0, MODE_TICK,      8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b0, 16'd0, MODE_STOP,      8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b1, 16'd2, MODE_READ_ACK,  8'h00, 1'b1, 1'b1, 1'b0, '0);
    add_row(1'b0, 16'd0, MODE_STOP,      8'h00, 1'b0, 1'b1, 1'b0, '0);
    add_row(1'b1, 16'd1, MODE_WRITE,     8'h5A, 1'b0, 1'b1, 1'b0, '0);

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < plan_len; i++) begin
      if (plan[i].set_half) write_half(plan[i].half);
      send_item(plan[i].item, plan[i].typed, plan[i].want);
      if (plan[i].run_out) run_out(plan[i].item.sda_in);
    end

    for (int p = 0; p < 3; p++) begin
      send_gap_pct = (p == 0) ? 21 : (p == 1) ? 76 : 0;
      recv_gap_pct = (p == 0) ? 76 : (p == 1) ? 21 : 0;
      for (int s = 0; s < 4; s++) begin
        write_half((s == 0) ? 16'd0 : (s == 1) ? 16'd1 : 16'($urandom_range(2, 5)));
        random_run(35);
      end
    end

    // widest half period: only the first hold of the start is seen
    write_half(16'hFFFF);
    send_item({MODE_START, 8'h00, 1'b0}, 1'b0, '0);
    random_run(40);

    push <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("i2c_master_byte_engine_test passed");
    end else begin
      $display("i2c_master_byte_engine_test failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/i2cm_pkg.sv
sv/i2cm_fifo.sv
sv/i2cm_front.sv
sv/i2cm_engine.sv
sv/i2c_master_byte_engine.sv
verif/i2c_master_byte_engine_test.sv
